@@ hdl/wase_pkg.sv @@
// ----------------------------------------------------------------------------
// Windowed ack stream endpoint package
// Types, codes and constants shared by the endpoint modules.
// ----------------------------------------------------------------------------
package wase_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SEND    = 3'd1,
        PH_RECV    = 3'd2,
        PH_TIMEOUT = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE     = 3'd0,
        K_DATA     = 3'd1,
        K_ACKREQ   = 3'd2,
        K_COMPLETE = 3'd3,
        K_ACK      = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        M_START_SEND = 3'd0,
        M_START_RECV = 3'd1,
        M_STOP       = 3'd2,
        M_TICK       = 3'd3,
        M_SOURCE     = 3'd4,
        M_CTRL_PKT   = 3'd5,
        M_DATA_PKT   = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        C_ACK_REQ  = 2'd0,
        C_ACK      = 2'd1,
        C_COMPLETE = 2'd2
    } t_cmd;

    localparam logic       REG_TIMEOUT     = 1'b0;
    localparam logic       REG_WINDOW      = 1'b1;
    localparam logic [31:0] TIMEOUT_RST    = 32'd30000;
    localparam logic [31:0] WINDOW_RST     = 32'd4096;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now_ms;
        logic [15:0] chunk_bytes;
        logic [1:0]  ctrl_command;
        logic [31:0] ctrl_count;
        logic [7:0]  stream_tag;
        logic        sink_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  send_kind;
        logic [31:0] send_count;
        logic [7:0]  send_tag;
        logic        handled;
        logic        stream_done;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic [31:0] timeout_ms;
        logic [31:0] window_bytes;
    } t_cfg;

endpackage

@@ hdl/wase_cfg.sv @@
// ----------------------------------------------------------------------------
// Endpoint configuration registers
// APB register file holding the timeout and the ack window size.
// ----------------------------------------------------------------------------
module wase_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output wase_pkg::t_cfg  o_cfg
);
    import wase_pkg::*;

    logic [31:0] r_timeout;
    logic [31:0] r_window;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_window  <= WINDOW_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_WINDOW) begin
                r_window <= pwdata;
            end else begin
                r_timeout <= pwdata;
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_TIMEOUT) begin
            prdata = r_timeout;
        end else begin
            prdata = r_window;
        end
    end

    assign o_cfg.timeout_ms   = r_timeout;
    assign o_cfg.window_bytes = r_window;

endmodule

@@ hdl/wase_core.sv @@
// ----------------------------------------------------------------------------
// Endpoint protocol core
// Holds the stream state and turns one event into one or two result beats.
// ----------------------------------------------------------------------------
module wase_core #(
    parameter int MAX_CHUNK_BYTES = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wase_pkg::t_cfg       i_cfg,
    input  wase_pkg::t_in_item   i_item,
    input  logic                 i_fire,
    output wase_pkg::t_out_item  o_res0,
    output wase_pkg::t_out_item  o_res1,
    output logic                 o_two
);
    import wase_pkg::*;

    localparam logic [15:0] MaxChunk = 16'(MAX_CHUNK_BYTES);

    t_phase      r_phase, n_phase;
    logic        r_await, n_await;
    logic [31:0] r_last, n_last;
    logic [31:0] r_count, n_count;

    logic [31:0] elapsed;
    logic        timeout_hit;
    logic [15:0] chunk_clip;
    logic [15:0] add_bytes;
    logic [32:0] sum;
    logic [31:0] sat_sum;
    logic        tick_req;
    logic        src_ok;
    logic        src_req;
    logic        ack_match;

    assign elapsed     = i_item.now_ms - r_last;
    assign timeout_hit = elapsed > i_cfg.timeout_ms;
    assign chunk_clip  = (i_item.chunk_bytes > MaxChunk) ? MaxChunk : i_item.chunk_bytes;
    assign add_bytes   = (t_mode'(i_item.mode) == M_DATA_PKT) ? i_item.chunk_bytes
                                                              : chunk_clip;
    assign sum         = {1'b0, r_count} + {17'd0, add_bytes};
    assign sat_sum     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign tick_req    = (r_phase == PH_SEND) && !r_await
                         && (r_count >= i_cfg.window_bytes) && (r_count != 32'd0);
    assign src_ok      = (r_phase == PH_SEND) && !r_await
                         && (r_count < i_cfg.window_bytes);
    assign src_req     = sat_sum >= i_cfg.window_bytes;
    assign ack_match   = (r_phase == PH_RECV) && (r_count == i_item.ctrl_count);

    always_comb begin
        n_phase = r_phase;
        n_await = r_await;
        n_last  = r_last;
        n_count = r_count;
        case (t_mode'(i_item.mode))
            M_START_SEND: begin
                n_phase = PH_SEND;
                n_await = 1'b0;
            end
            M_START_RECV: begin
                n_phase = PH_RECV;
                n_last  = i_item.now_ms;
            end
            M_STOP: begin
                n_phase = PH_IDLE;
            end
            M_TICK: begin
                if (r_phase == PH_SEND && r_await) begin
                    if (timeout_hit) begin
                        n_phase = PH_TIMEOUT;
                        n_last  = 32'd0;
                    end
                end else if (tick_req) begin
                    n_await = 1'b1;
                    n_last  = i_item.now_ms;
                end else if (r_phase == PH_RECV && timeout_hit) begin
                    n_phase = PH_TIMEOUT;
                    n_last  = 32'd0;
                end
            end
            M_SOURCE: begin
                if (src_ok) begin
                    if (i_item.chunk_bytes == 16'd0) begin
                        n_last  = i_item.now_ms;
                        n_phase = PH_DONE;
                    end else begin
                        n_count = sat_sum;
                        if (src_req) begin
                            n_await = 1'b1;
                            n_last  = i_item.now_ms;
                        end
                    end
                end
            end
            M_CTRL_PKT: begin
                if (t_cmd'(i_item.ctrl_command) == C_ACK_REQ && ack_match) begin
                    n_count = 32'd0;
                    n_last  = i_item.now_ms;
                end else if (t_cmd'(i_item.ctrl_command) == C_ACK && r_await) begin
                    n_count = 32'd0;
                    n_last  = i_item.now_ms;
                    n_await = 1'b0;
                end
            end
            M_DATA_PKT: begin
                if (r_phase == PH_RECV) begin
                    if (!i_item.sink_ok) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_count = sat_sum;
                        n_last  = i_item.now_ms;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res0 = '0;
        o_res1 = '0;
        o_two  = 1'b0;
        o_res1.send_kind  = K_ACKREQ;
        o_res1.send_count = i_cfg.window_bytes;
        o_res1.send_tag   = i_item.stream_tag;
        case (t_mode'(i_item.mode))
            M_TICK: begin
                if (!(r_phase == PH_SEND && r_await) && tick_req) begin
                    o_res0.send_kind  = K_ACKREQ;
                    o_res0.send_count = i_cfg.window_bytes;
                end
            end
            M_SOURCE: begin
                if (src_ok) begin
                    if (i_item.chunk_bytes == 16'd0) begin
                        o_res0.send_kind   = K_COMPLETE;
                        o_res0.send_tag    = i_item.stream_tag;
                        o_res0.stream_done = 1'b1;
                    end else begin
                        o_res0.send_kind  = K_DATA;
                        o_res0.send_count = {16'd0, chunk_clip};
                        o_res0.send_tag   = i_item.stream_tag;
                        o_two             = src_req;
                    end
                end
            end
            M_CTRL_PKT: begin
                o_res0.handled = 1'b1;
                if (t_cmd'(i_item.ctrl_command) == C_ACK_REQ && ack_match) begin
                    o_res0.send_kind  = K_ACK;
                    o_res0.send_count = i_item.ctrl_count;
                    o_res0.send_tag   = i_item.stream_tag;
                end else if (t_cmd'(i_item.ctrl_command) == C_COMPLETE) begin
                    o_res0.stream_done = 1'b1;
                end
            end
            M_DATA_PKT: begin
                o_res0.handled = (r_phase == PH_RECV) && i_item.sink_ok;
            end
            default: begin
            end
        endcase
        o_res0.phase       = n_phase;
        o_res1.phase       = n_phase;
        o_res0.last_result = !o_two;
        o_res1.last_result = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_await <= 1'b0;
            r_last  <= 32'd0;
            r_count <= 32'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_await <= n_await;
            r_last  <= n_last;
            r_count <= n_count;
        end
    end

endmodule

@@ hdl/wase_outq.sv @@
// ----------------------------------------------------------------------------
// Endpoint result queue
// Two-entry result register that takes one or two beats per cycle.
// ----------------------------------------------------------------------------
module wase_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_two,
    input  wase_pkg::t_out_item  i_res0,
    input  wase_pkg::t_out_item  i_res1,
    input  logic                 i_stall,
    output logic                 o_valid,
    output wase_pkg::t_out_item  o_data,
    output logic [1:0]           o_space
);
    import wase_pkg::*;

    t_out_item  r_q [2];
    t_out_item  n_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] cnt_rem;
    logic       pop;

    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_q[0];
    assign pop     = o_valid && !i_stall;
    assign cnt_rem = r_cnt - {1'b0, pop};
    assign o_space = 2'd2 - cnt_rem;

    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        n_cnt  = cnt_rem;
        if (i_push) begin
            n_q[cnt_rem[0]] = i_res0;
            if (i_two) begin
                n_q[1] = i_res1;
                n_cnt  = cnt_rem + 2'd2;
            end else begin
                n_cnt  = cnt_rem + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

endmodule

@@ hdl/windowed_ack_stream_endpoint_unit.sv @@
// ----------------------------------------------------------------------------
// Windowed ack stream endpoint
// Sender or receiver endpoint with byte-window ack flow control, counts only.
// ----------------------------------------------------------------------------
// The input channel carries one event per beat: a command, a time tick, a
// source chunk size or a received control or data packet. The output channel
// carries one or two result beats per event; last_result marks the final one.
// The user must write timeout and window size via the APB port only while idle (not enforced).
//
// An accepted event is held in an input register and is processed once the
// two-entry result queue has room for its results, which are then written to
// the queue. One event per cycle is sustained while the output is not stalled
// and events yield single beats; a source chunk that fills the window yields
// a data beat and an ack request beat, which take turns on the single output
// port. When the receiver stalls, the queue fills and o_in_stall rises once
// the held event's results no longer fit.
//
// Reset clears the stream state to idle with zero counters, empties the queue
// and restores the timeout to 30000 ms and the window to 4096 bytes.
// ----------------------------------------------------------------------------
module windowed_ack_stream_endpoint_unit #(
    parameter int MAX_CHUNK_BYTES = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  wase_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output wase_pkg::t_out_item  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import wase_pkg::*;

    t_cfg       cfg;
    t_in_item   r_item;
    logic       r_item_valid;
    t_out_item  res0;
    t_out_item  res1;
    logic       two;
    logic [1:0] space;
    logic       fire;

    wase_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign fire       = r_item_valid && (two ? (space == 2'd2) : (space != 2'd0));
    assign o_in_stall = r_item_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_in_data;
        end
    end

    wase_core #(
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (r_item),
        .i_fire  (fire),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_two   (two)
    );

    wase_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_two   (two),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_space (space)
    );

    a_fire_shows_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid
    ) else $error("processed event left no result beat");

    a_pair_head_not_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        fire && two |=> o_out_valid && !o_out_data.last_result
    ) else $error("first beat of a result pair marked last");

    a_held_event_kept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_item_valid && !fire |=> r_item_valid && $stable(r_item)
    ) else $error("held event lost before processing");

endmodule
